// ===== sv/btr_pkg.sv =====
// shared types, constants and helpers of the background tile renderer
package btr_pkg;

  localparam int unsigned VramAddrW = 13;
  localparam int unsigned BankIdxW  = VramAddrW - 1;
  localparam int unsigned BankDepth = 1 << BankIdxW;

  localparam logic [VramAddrW-1:0] MapLowBase     = 13'h1800;
  localparam logic [VramAddrW-1:0] MapHighBase    = 13'h1C00;
  localparam logic [VramAddrW-1:0] SignedDataBase = 13'h1000;

  // control register bits
  localparam int unsigned CtrlDisplayBit = 7;
  localparam int unsigned CtrlDataSelBit = 4;
  localparam int unsigned CtrlMapSelBit  = 3;

  typedef enum logic [1:0] {
    RegControl = 2'd0,
    RegScrollX = 2'd1,
    RegScrollY = 2'd2,
    RegPalette = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] control;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] palette;
  } cfg_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic                 is_write;
    logic [VramAddrW-1:0] waddr;
    logic [7:0]           wdata;
    logic [7:0]           px;
    logic [7:0]           ln;
    logic                 display;
    logic [VramAddrW-1:0] map_addr;
    logic [2:0]           fine_x;
    logic [2:0]           fine_y;
  } cmd_t;

  typedef struct packed {
    logic [7:0] px;
    logic [7:0] ln;
    logic [1:0] shade;
  } pix_t;

  function automatic logic [7:0] shade_level(input logic [1:0] shade);
    logic [7:0] lvl;
    case (shade)
      2'd0:    lvl = 8'hFF;
      2'd1:    lvl = 8'd192;
      2'd2:    lvl = 8'd96;
      default: lvl = 8'd0;
    endcase
    return lvl;
  endfunction

endpackage

// ===== sv/btr_queue.sv =====
// small register fifo used between the pipeline parts
module btr_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/btr_front.sv =====
// front part: takes items, applies scroll and forms the tile map address
module btr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btr_pkg::cfg_t       cfg_i,
  input  logic                push_i,
  output logic                full_o,
  input  logic                kind_i,
  input  logic [12:0]         vram_address_i,
  input  logic [7:0]          write_data_i,
  input  logic [7:0]          pixel_x_i,
  input  logic [7:0]          line_i,
  output logic                cmd_push_o,
  output btr_pkg::cmd_t       cmd_o,
  input  logic                cmd_full_i
);

  logic          valid_q, valid_d;
  btr_pkg::cmd_t cmd_q, cmd_d;
  logic          accept;
  logic [8:0]    sx_sum, sy_sum;
  logic [7:0]    sx, sy;

  assign full_o     = valid_q && cmd_full_i;
  assign accept     = push_i && !full_o;
  assign cmd_push_o = valid_q && !cmd_full_i;
  assign cmd_o      = cmd_q;

  assign sx_sum = {1'b0, pixel_x_i} + {1'b0, cfg_i.scroll_x};
  assign sy_sum = {1'b0, line_i} + {1'b0, cfg_i.scroll_y};
  assign sx     = sx_sum[7:0];
  assign sy     = sy_sum[7:0];

  always_comb begin
    cmd_d          = cmd_q;
    cmd_d.is_write = !kind_i;
    cmd_d.waddr    = vram_address_i;
    cmd_d.wdata    = write_data_i;
    cmd_d.px       = pixel_x_i;
    cmd_d.ln       = line_i;
    cmd_d.display  = cfg_i.control[btr_pkg::CtrlDisplayBit];
    // 32x32 map: row from coarse y, column from coarse x
    cmd_d.map_addr = (cfg_i.control[btr_pkg::CtrlMapSelBit] ? btr_pkg::MapHighBase
                                                            : btr_pkg::MapLowBase)
                     + btr_pkg::VramAddrW'({sy[7:3], sx[7:3]});
    cmd_d.fine_x   = sx[2:0];
    cmd_d.fine_y   = sy[2:0];
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cmd_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== sv/btr_back.sv =====
// back part: video memory, tile fetch, bitplane fetch and palette lookup
module btr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  btr_pkg::cfg_t cfg_i,
  input  logic          cmd_empty_i,
  input  btr_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          pix_full_i,
  output logic          pix_push_o,
  output btr_pkg::pix_t pix_o
);

  // memory split into even and odd bytes so both bitplanes come in one read
  logic [7:0] bank0_mem [btr_pkg::BankDepth];
  logic [7:0] bank1_mem [btr_pkg::BankDepth];

  logic [7:0] map0_q, map1_q, row0_q, row1_q;

  logic          b1_valid_q, b1_valid_d;
  btr_pkg::cmd_t b1_cmd_q;
  logic          b2_valid_q, b2_valid_d;
  logic [7:0]    b2_px_q, b2_ln_q;
  logic          b2_display_q;
  logic [2:0]    b2_fine_x_q;

  logic                          adv;
  logic                          wr_en;
  logic [btr_pkg::BankIdxW-1:0]  map_idx, row_idx, wr_idx;
  logic [7:0]                    tile;
  logic                          row_hi_bit;
  logic [2:0]                    bit_sel;
  logic [1:0]                    cid;
  logic [1:0]                    shade;

  assign adv        = !(b2_valid_q && pix_full_i);
  assign cmd_pop_o  = adv && !cmd_empty_i;
  assign pix_push_o = b2_valid_q && !pix_full_i;

  assign wr_en   = cmd_pop_o && cmd_i.is_write;
  assign wr_idx  = cmd_i.waddr[btr_pkg::VramAddrW-1:1];
  assign map_idx = cmd_i.map_addr[btr_pkg::VramAddrW-1:1];

  // signed addressing: base 0x1000, indexes 128..255 fall back by 0x1000
  assign tile       = b1_cmd_q.map_addr[0] ? map1_q : map0_q;
  assign row_hi_bit = cfg_i.control[btr_pkg::CtrlDataSelBit] ? 1'b0 : !tile[7];
  assign row_idx    = {row_hi_bit, tile, b1_cmd_q.fine_y};

  always_ff @(posedge clk_i) begin
    if (wr_en && !cmd_i.waddr[0]) begin
      bank0_mem[wr_idx] <= cmd_i.wdata;
    end
    if (adv) begin
      map0_q <= bank0_mem[map_idx];
      row0_q <= bank0_mem[row_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && cmd_i.waddr[0]) begin
      bank1_mem[wr_idx] <= cmd_i.wdata;
    end
    if (adv) begin
      map1_q <= bank1_mem[map_idx];
      row1_q <= bank1_mem[row_idx];
    end
  end

  assign b1_valid_d = adv ? (cmd_pop_o && !cmd_i.is_write) : b1_valid_q;
  assign b2_valid_d = adv ? b1_valid_q : b2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= b1_valid_d;
      b2_valid_q <= b2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_cmd_q     <= cmd_i;
      b2_px_q      <= b1_cmd_q.px;
      b2_ln_q      <= b1_cmd_q.ln;
      b2_display_q <= b1_cmd_q.display;
      b2_fine_x_q  <= b1_cmd_q.fine_x;
    end
  end

  // leftmost pixel sits in bit 7
  assign bit_sel = ~b2_fine_x_q;
  assign cid     = {row1_q[bit_sel], row0_q[bit_sel]};

  always_comb begin
    case (cid)
      2'd0:    shade = cfg_i.palette[1:0];
      2'd1:    shade = cfg_i.palette[3:2];
      2'd2:    shade = cfg_i.palette[5:4];
      default: shade = cfg_i.palette[7:6];
    endcase
  end

  assign pix_o.px    = b2_px_q;
  assign pix_o.ln    = b2_ln_q;
  assign pix_o.shade = b2_display_q ? shade : 2'd0;

endmodule

// ===== sv/background_tile_pixel_renderer_core.sv =====
// top level of the background tile renderer
// Usage: items enter through a queue-style port: push_i with the payload, taken
// when full_o is low. kind_i low stores write_data_i at vram_address_i in the
// 8 KiB video memory and gives no result; kind_i high renders pixel
// (pixel_x_i, line_i) and gives one result. Results leave in item order
// through a second queue-style port: while empty_o is low the oldest pixel is
// on out_x_o, out_line_o, shade_o and the rgb ports, and pop_i takes it.
// Registers are written over the cfg channel (cfg_ready_o is always high):
// 0 control, 1 scroll x, 2 scroll y, 3 palette. The user must write them
// only while no item is in flight; the block itself does not enforce this.
// A write lands in memory when the back takes it, ahead of any later render.
// Throughput: one item per cycle unless the result queue backs up, set by the
// one read per bank and port the tile and bitplane fetches each make per cycle.
// Reset clears the registers and all queues; memory contents stay undefined
// until software loads them. When pop_i stays low the result queue fills, the
// back pipeline holds, the middle queue fills, and full_o rises.
module background_tile_pixel_renderer_core #(
  parameter int unsigned CMD_DEPTH = 4,
  parameter int unsigned PIX_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic        kind_i,
  input  logic [12:0] vram_address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  line_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  out_x_o,
  output logic [7:0]  out_line_o,
  output logic [1:0]  shade_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);

  localparam int unsigned CmdW = $bits(btr_pkg::cmd_t);
  localparam int unsigned PixW = $bits(btr_pkg::pix_t);

  btr_pkg::cfg_t cfg_q, cfg_d;
  btr_pkg::cmd_t front_cmd, back_cmd;
  btr_pkg::pix_t back_pix, out_pix;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic          pix_push, pix_full;
  logic [CmdW-1:0] back_cmd_bits;
  logic [PixW-1:0] out_pix_bits;
  logic [7:0]      level;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (btr_pkg::cfg_idx_e'(cfg_index_i))
        btr_pkg::RegControl: cfg_d.control  = cfg_data_i;
        btr_pkg::RegScrollX: cfg_d.scroll_x = cfg_data_i;
        btr_pkg::RegScrollY: cfg_d.scroll_y = cfg_data_i;
        btr_pkg::RegPalette: cfg_d.palette  = cfg_data_i;
        default:             cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  btr_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i          (cfg_q),
    .push_i,
    .full_o,
    .kind_i,
    .vram_address_i,
    .write_data_i,
    .pixel_x_i,
    .line_i,
    .cmd_push_o     (cmd_push),
    .cmd_o          (front_cmd),
    .cmd_full_i     (cmd_full)
  );

  btr_queue #(
    .Width (CmdW),
    .Depth (CMD_DEPTH)
  ) u_cmd_queue (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd_bits),
    .empty_o (cmd_empty)
  );

  assign back_cmd = btr_pkg::cmd_t'(back_cmd_bits);

  btr_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .pix_full_i  (pix_full),
    .pix_push_o  (pix_push),
    .pix_o       (back_pix)
  );

  btr_queue #(
    .Width (PixW),
    .Depth (PIX_DEPTH)
  ) u_pix_queue (
    .clk_i,
    .rst_ni,
    .push_i  (pix_push),
    .data_i  (back_pix),
    .full_o  (pix_full),
    .pop_i,
    .data_o  (out_pix_bits),
    .empty_o
  );

  assign out_pix    = btr_pkg::pix_t'(out_pix_bits);
  assign level      = btr_pkg::shade_level(out_pix.shade);
  assign out_x_o    = out_pix.px;
  assign out_line_o = out_pix.ln;
  assign shade_o    = out_pix.shade;
  assign red_o      = level;
  assign green_o    = level;
  assign blue_o     = level;

endmodule

// ===== test/btr_checker.sv =====
// pixel predictor and result checker of the background tile renderer
module btr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        push_i,
  input  logic        full_o,
  input  logic        kind_i,
  input  logic [12:0] vram_address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  line_i,
  input  logic        empty_o,
  input  logic        pop_i,
  input  logic [7:0]  out_x_o,
  input  logic [7:0]  out_line_o,
  input  logic [1:0]  shade_o,
  input  logic [7:0]  red_o,
  input  logic [7:0]  green_o,
  input  logic [7:0]  blue_o,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // rgb level of shade s sits at bits 8s+7:8s
  localparam logic [31:0] LevelTable = {8'd0, 8'd96, 8'd192, 8'd255};

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] ln;
    logic [1:0] shade;
  } pixel_t;

  logic [7:0] vram_image [8192];
  logic [7:0] ctrl_q, scroll_x_q, scroll_y_q, palette_q;
  pixel_t     pending_pixels [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [1:0] shade_at(input logic [7:0] px, input logic [7:0] ln);
    logic [7:0]  sx, sy, tile, lo, hi;
    logic [12:0] map_pos, row;
    logic [2:0]  bitpos;
    logic [1:0]  cid;
    if (!ctrl_q[btr_pkg::CtrlDisplayBit]) return 2'd0;
    sx      = px + scroll_x_q;
    sy      = ln + scroll_y_q;
    map_pos = (ctrl_q[btr_pkg::CtrlMapSelBit] ? btr_pkg::MapHighBase : btr_pkg::MapLowBase)
              + {3'b000, sy[7:3], sx[7:3]};
    tile    = vram_image[map_pos];
    if (ctrl_q[btr_pkg::CtrlDataSelBit]) begin
      row = {1'b0, tile, sy[2:0], 1'b0};
    end else begin
      // signed tile index, sign-extended and scaled by 16 bytes per tile
      row = btr_pkg::SignedDataBase + {tile[7], tile, 4'b0000} + {9'd0, sy[2:0], 1'b0};
    end
    lo     = vram_image[row];
    hi     = vram_image[row + 13'd1];
    bitpos = ~sx[2:0];
    cid    = {hi[bitpos], lo[bitpos]};
    return palette_q[2*cid +: 2];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic check_pixel();
    pixel_t     want;
    logic [7:0] level;
    if (pending_pixels.size() == 0) begin
      report_mismatch($sformatf("pixel x=%0d line=%0d with none pending", out_x_o, out_line_o));
      return;
    end
    want  = pending_pixels.pop_front();
    level = LevelTable[8*want.shade +: 8];
    if (out_x_o !== want.x)
      report_mismatch($sformatf("out_x %0d, want %0d", out_x_o, want.x));
    if (out_line_o !== want.ln)
      report_mismatch($sformatf("out_line %0d, want %0d", out_line_o, want.ln));
    if (shade_o !== want.shade)
      report_mismatch($sformatf("shade %0d, want %0d at x=%0d line=%0d",
                                shade_o, want.shade, want.x, want.ln));
    if (red_o !== level)
      report_mismatch($sformatf("red %0d, want %0d", red_o, level));
    if (green_o !== level)
      report_mismatch($sformatf("green %0d, want %0d", green_o, level));
    if (blue_o !== level)
      report_mismatch($sformatf("blue %0d, want %0d", blue_o, level));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      ctrl_q     = '0;
      scroll_x_q = '0;
      scroll_y_q = '0;
      palette_q  = '0;
      pending_pixels.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (btr_pkg::cfg_idx_e'(cfg_index_i))
          btr_pkg::RegControl: ctrl_q     = cfg_data_i;
          btr_pkg::RegScrollX: scroll_x_q = cfg_data_i;
          btr_pkg::RegScrollY: scroll_y_q = cfg_data_i;
          btr_pkg::RegPalette: palette_q  = cfg_data_i;
          default:             ;
        endcase
      end
      // the oldest result leaves before a new item joins
      if (pop_i && !empty_o) check_pixel();
      if (push_i && !full_o) begin
        if (kind_i) begin
          pending_pixels.push_back('{x: pixel_x_i, ln: line_i,
                                     shade: shade_at(pixel_x_i, line_i)});
        end else begin
          vram_image[vram_address_i] = write_data_i;
        end
      end
    end
    pending_o = pending_pixels.size();
  end

endmodule

// ===== test/tb_top.sv =====
// stimulus, clocking and verdict for the background tile renderer
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget = 1400;
  localparam int StallLimit = 2000;
  localparam int SettleCycles = 8;

  localparam logic KindWrite  = 1'b0;
  localparam logic KindRender = 1'b1;

  localparam logic [7:0] DisplayOn    = 8'(1 << btr_pkg::CtrlDisplayBit);
  localparam logic [7:0] UnsignedData = 8'(1 << btr_pkg::CtrlDataSelBit);
  localparam logic [7:0] HighMap      = 8'(1 << btr_pkg::CtrlMapSelBit);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic        kind_i = 1'b0;
  logic [12:0] vram_address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic [7:0]  pixel_x_i = '0;
  logic [7:0]  line_i = '0;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic [7:0]  out_x_o;
  logic [7:0]  out_line_o;
  logic [1:0]  shade_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;

  int fail_n;
  int pending_n;

  // what software has loaded so far, so a render never reads an unwritten byte
  logic [7:0] mem_image [8192];
  bit         mem_loaded [8192];
  logic [7:0] ctl_q = '0, sx_q = '0, sy_q = '0;
  int         items_sent = 0;
  int         burst_left = 4;

  background_tile_pixel_renderer_core u_top (.*);

  btr_checker u_checker (
    .*,
    .fail_count_o(fail_n),
    .pending_o   (pending_n)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [12:0] map_cell(input logic [7:0] px, input logic [7:0] ln);
    logic [7:0] sx, sy;
    sx = px + sx_q;
    sy = ln + sy_q;
    return (ctl_q[btr_pkg::CtrlMapSelBit] ? btr_pkg::MapHighBase : btr_pkg::MapLowBase)
           + {3'b000, sy[7:3], sx[7:3]};
  endfunction

  function automatic logic [12:0] plane_addr(input logic [7:0] tile, input logic [7:0] ln);
    logic [7:0] sy;
    sy = ln + sy_q;
    if (ctl_q[btr_pkg::CtrlDataSelBit]) return {1'b0, tile, sy[2:0], 1'b0};
    return btr_pkg::SignedDataBase + {tile[7], tile, 4'b0000} + {9'd0, sy[2:0], 1'b0};
  endfunction

  task automatic scramble_fields();
    kind_i         = 1'($urandom);
    vram_address_i = 13'($urandom);
    write_data_i   = 8'($urandom);
    pixel_x_i      = 8'($urandom);
    line_i         = 8'($urandom);
  endtask

  task automatic drive_item(input logic k, input logic [12:0] addr, input logic [7:0] data,
                            input logic [7:0] px, input logic [7:0] ln);
    int gap;
    push_i         = 1'b1;
    kind_i         = k;
    vram_address_i = addr;
    write_data_i   = data;
    pixel_x_i      = px;
    line_i         = ln;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push_i = 1'b0;
        scramble_fields();
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic load_byte(input logic [12:0] addr, input logic [7:0] data);
    drive_item(KindWrite, addr, data, 8'($urandom), 8'($urandom));
    mem_image[addr]  = data;
    mem_loaded[addr] = 1'b1;
  endtask

  task automatic render(input logic [7:0] px, input logic [7:0] ln);
    logic [12:0] map_pos, row;
    if (ctl_q[btr_pkg::CtrlDisplayBit]) begin
      map_pos = map_cell(px, ln);
      if (!mem_loaded[map_pos]) load_byte(map_pos, 8'($urandom));
      row = plane_addr(mem_image[map_pos], ln);
      if (!mem_loaded[row]) load_byte(row, 8'($urandom));
      if (!mem_loaded[row + 13'd1]) load_byte(row + 13'd1, 8'($urandom));
    end
    drive_item(KindRender, 13'($urandom), 8'($urandom), px, ln);
  endtask

  // nothing in flight: every pixel back and the last write landed
  task automatic settle();
    push_i = 1'b0;
    while (pending_n != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input btr_pkg::cfg_idx_e idx, input logic [7:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = 8'($urandom);
  endtask

  task automatic set_regs(input logic [7:0] ctl, input logic [7:0] sx, input logic [7:0] sy,
                          input logic [7:0] pal);
    settle();
    write_reg(btr_pkg::RegControl, ctl);
    write_reg(btr_pkg::RegScrollX, sx);
    write_reg(btr_pkg::RegScrollY, sy);
    write_reg(btr_pkg::RegPalette, pal);
    ctl_q = ctl;
    sx_q  = sx;
    sy_q  = sy;
  endtask

  function automatic logic [7:0] pick_scroll();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // receiver: stall pattern picked anew for each span of random length
  initial begin
    int mode, span, n;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 64);
      for (n = 0; n < span; n++) begin
        @(negedge clk_i);
        case (mode)
          0:       pop_i = 1'b1;
          1:       pop_i = 1'($urandom);
          2:       pop_i = (n % 4 == 3);
          default: pop_i = (n % 24 == 23);
        endcase
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o))
        idle = 0;
      else
        idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [7:0] ctl, pal, px, ln;
    int n;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // display off after reset: white whatever memory holds
    load_byte(13'h1FFF, 8'h00);
    load_byte(13'h0000, 8'hFF);
    render(8'd0, 8'd0);
    render(8'd255, 8'd255);

    // unsigned tile data, low map: one tile row giving all four colour ids
    set_regs(DisplayOn | UnsignedData, 8'h00, 8'h00, 8'hE4);
    load_byte(btr_pkg::MapLowBase, 8'hFF);
    load_byte(13'h0FF0, 8'h0F);
    load_byte(13'h0FF1, 8'h33);
    render(8'd0, 8'd0);
    render(8'd2, 8'd0);
    render(8'd4, 8'd0);
    render(8'd7, 8'd0);

    // signed tile data, high map, full scroll wrapping
    set_regs(DisplayOn | HighMap, 8'hFF, 8'hFF, 8'h1B);
    load_byte(map_cell(8'd1, 8'd0), 8'h80);
    render(8'd1, 8'd0);
    load_byte(map_cell(8'd9, 8'd0), 8'h7F);
    render(8'd9, 8'd0);
    render(8'd159, 8'd143);

    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 7))
        0:       ctl = 8'hFF;
        1:       ctl = 8'h00;
        default: ctl = 8'($urandom) | DisplayOn;
      endcase
      case ($urandom_range(0, 5))
        0:       pal = 8'h00;
        1:       pal = 8'hFF;
        default: pal = 8'($urandom);
      endcase
      set_regs(ctl, pick_scroll(), pick_scroll(), pal);
      n = $urandom_range(60, 200);
      for (int k = 0; k < n && items_sent < ItemTarget; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          // mostly on screen, now and then past its edges
          if ($urandom_range(0, 6) == 0) begin
            px = 8'($urandom);
            ln = 8'($urandom);
          end else begin
            px = 8'($urandom_range(0, 159));
            ln = 8'($urandom_range(0, 143));
          end
          render(px, ln);
        end else begin
          load_byte(13'($urandom), 8'($urandom));
        end
      end
    end

    settle();
    if (fail_n == 0 && pending_n == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
